/* design/sed_pkg.sv */
// Shared types and constants for the string escape decoder.
// No dependencies; imported by sed_decode, sed_queue and string_escape_decoder.
package sed_pkg;

    localparam int CharW   = 21;
    localparam int ValueW  = 32;
    localparam int DelimW  = 7;
    localparam int DigitsW = 4;

    // Result queue geometry
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_CLOSE   = 2'd1,
        KIND_NEWLINE = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NEWLINE   = 3'd1,
        ERR_UNKNOWN   = 3'd2,
        ERR_BAD_HEX   = 3'd3,
        ERR_BAD_OCT   = 3'd4,
        ERR_OCT_RANGE = 3'd5
    } error_code_t;

    typedef struct packed {
        result_kind_t      kind;
        logic [ValueW-1:0] value;
        logic              is_byte;
        error_code_t       err;
        logic              last;
    } result_t;

    // Up to two results come out of one character
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_out_t;

    // Character codes
    localparam logic [CharW-1:0] CH_NEWLINE   = 21'd10;
    localparam logic [CharW-1:0] CH_BACKSLASH = 21'd92;
    localparam logic [CharW-1:0] CH_ZERO      = 21'd48;
    localparam logic [CharW-1:0] CH_SEVEN     = 21'd55;
    localparam logic [CharW-1:0] CH_NINE      = 21'd57;
    localparam logic [CharW-1:0] CH_UPPER_A   = 21'd65;
    localparam logic [CharW-1:0] CH_UPPER_F   = 21'd70;
    localparam logic [CharW-1:0] CH_UPPER_U   = 21'd85;
    localparam logic [CharW-1:0] CH_LOWER_A   = 21'd97;
    localparam logic [CharW-1:0] CH_LOWER_B   = 21'd98;
    localparam logic [CharW-1:0] CH_LOWER_F   = 21'd102;
    localparam logic [CharW-1:0] CH_LOWER_N   = 21'd110;
    localparam logic [CharW-1:0] CH_LOWER_R   = 21'd114;
    localparam logic [CharW-1:0] CH_LOWER_T   = 21'd116;
    localparam logic [CharW-1:0] CH_LOWER_U   = 21'd117;
    localparam logic [CharW-1:0] CH_LOWER_V   = 21'd118;
    localparam logic [CharW-1:0] CH_LOWER_X   = 21'd120;

    localparam logic [DelimW-1:0] DELIM_RESET = 7'd34;
    localparam logic [ValueW-1:0] OCT_BYTE_MAX = 32'd255;

    localparam logic [DigitsW-1:0] HEX_BYTE_DIGITS  = 4'd2;
    localparam logic [DigitsW-1:0] HEX_SHORT_DIGITS = 4'd4;
    localparam logic [DigitsW-1:0] HEX_LONG_DIGITS  = 4'd8;
    localparam logic [DigitsW-1:0] OCT_MORE_DIGITS  = 4'd2;

    function automatic result_t make_result(result_kind_t kind, logic [ValueW-1:0] value,
                                            logic is_byte, error_code_t err);
        result_t r;
        r.kind    = kind;
        r.value   = value;
        r.is_byte = is_byte;
        r.err     = err;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

/* design/string_escape_decoder.sv */
// Top level of the string escape decoder: APB register, decode and result queue.
// Depends on sed_pkg, sed_decode and sed_queue.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+--------------------------------------------
//  s_       | in        | s_valid/s_ready   | s_char_code
//  m_       | out       | m_valid/m_ready   | m_result_kind, m_char_value, m_is_byte,
//           |           |                   | m_error_code, m_last_result
//  apb      | in        | psel/penable      | paddr, pwdata, prdata (delimiter register)
//
// One character is taken per cycle while s_ready is high; its results are in the queue the next cycle.
// A character that yields two results needs two output transfers, so sustained
// rate is one character per cycle when each yields at most one result and m_ready stays high.
// s_ready drops only when the four-entry result queue has fewer than two free slots.
// Reset (aresetn low, synchronous) empties the queue, clears the decode state and
// restores the delimiter to a double quote.
module string_escape_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input characters
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sed_pkg::CharW-1:0]     s_char_code,
    // Results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_result_kind,
    output logic [sed_pkg::ValueW-1:0]    m_char_value,
    output logic                          m_is_byte,
    output logic [2:0]                    m_error_code,
    output logic                          m_last_result,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sed_pkg::*;

    logic [DelimW-1:0]  delim_reg;
    logic               s_accept;
    logic               m_accept;
    logic               cfg_write;
    decode_out_t        dec_out;
    logic [1:0]         push_count;
    result_t            head;
    logic [QCntW-1:0]   q_count;

    assign s_accept  = s_valid && s_ready;
    assign m_accept  = m_valid && m_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Delimiter register: the only register, so every word address maps to it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
        end else if (cfg_write) begin
            delim_reg <= pwdata[DelimW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0 || paddr[1:0] != 2'd0)
                  ? {{(32-DelimW){1'b0}}, delim_reg} : '0;

    sed_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .char_code (s_char_code),
        .delim     (delim_reg),
        .dec_out   (dec_out)
    );

    assign push_count = s_accept ? dec_out.count : 2'd0;

    sed_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (push_count),
        .push_first  (dec_out.first),
        .push_second (dec_out.second),
        .pop         (m_accept),
        .head        (head),
        .count       (q_count)
    );

    // Accept a character only with room for two results
    assign s_ready = (q_count <= QCntW'(QDepth - 2));
    assign m_valid = (q_count != '0);

    assign m_result_kind = head.kind;
    assign m_char_value  = head.value;
    assign m_is_byte     = head.is_byte;
    assign m_error_code  = head.err;
    assign m_last_result = head.last;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCntW'(QDepth))
        else $error("result queue occupancy above depth");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept && m_accept) |=> (q_count == QCntW'($past(q_count) - 1'b1)))
        else $error("queue occupancy did not drop after a lone output transfer");

    a_delim_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_write |=> $stable(delim_reg))
        else $error("delimiter changed without a configuration write");

    a_no_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept && !m_accept) |=> $stable(q_count))
        else $error("queue occupancy changed with no transfer");
`endif

endmodule

/* design/sed_decode.sv */
// Escape decode: mode state plus single-pass next-state and result logic.
// Depends on sed_pkg.
module sed_decode (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [sed_pkg::CharW-1:0]   char_code,
    input  logic [sed_pkg::DelimW-1:0]  delim,
    output sed_pkg::decode_out_t        dec_out
);
    import sed_pkg::*;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESCAPE = 4'b0010,
        MODE_HEX    = 4'b0100,
        MODE_OCT    = 4'b1000
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [DigitsW-1:0]  left_reg, left_next;
    logic [ValueW-1:0]   acc_reg, acc_next;
    logic                byte_reg, byte_next;

    logic                plain_has;
    logic                plain_esc;
    result_t             plain_res;
    logic                is_delim;
    logic                hex_ok;
    logic [3:0]          hex_d;
    logic                oct_ok;
    logic [DigitsW-1:0]  left_dec;
    logic [ValueW-1:0]   acc_hex;
    logic [ValueW-1:0]   acc_oct;
    decode_out_t         dec;

    assign is_delim = (char_code == {{(CharW-DelimW){1'b0}}, delim});
    assign left_dec = left_reg - 4'd1;
    assign acc_hex  = {acc_reg[ValueW-5:0], hex_d};
    assign acc_oct  = {acc_reg[ValueW-4:0], char_code[2:0]};
    assign oct_ok   = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);

    // Classify a hex digit
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
            hex_d = char_code[3:0];
        end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_F) begin
            hex_d = 4'(char_code[3:0] + 4'd9);
        end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_F) begin
            hex_d = 4'(char_code[3:0] + 4'd9);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Handle the character as plain text
    always_comb begin
        plain_has = 1'b1;
        plain_esc = 1'b0;
        plain_res = make_result(KIND_CHAR, {{(ValueW-CharW){1'b0}}, char_code}, 1'b0, ERR_NONE);
        if (char_code == CH_NEWLINE) begin
            plain_res = make_result(KIND_NEWLINE, '0, 1'b0, ERR_NEWLINE);
        end else if (char_code == CH_BACKSLASH) begin
            plain_has = 1'b0;
            plain_esc = 1'b1;
        end else if (is_delim) begin
            plain_res = make_result(KIND_CLOSE, '0, 1'b0, ERR_NONE);
        end
    end

    // Next state and results
    always_comb begin
        mode_next  = mode_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        byte_next  = byte_reg;
        dec.count  = 2'd0;
        dec.first  = make_result(KIND_CHAR, '0, 1'b0, ERR_NONE);
        dec.second = make_result(KIND_CHAR, '0, 1'b0, ERR_NONE);

        unique case (mode_reg)
            MODE_NORMAL: begin
                if (plain_esc) begin
                    mode_next = MODE_ESCAPE;
                end
                if (plain_has) begin
                    dec.count = 2'd1;
                    dec.first = plain_res;
                end
            end
            MODE_ESCAPE: begin
                mode_next = MODE_NORMAL;
                dec.count = 2'd1;
                case (char_code) inside
                    CH_NEWLINE: begin
                        dec.count = 2'd0;
                    end
                    CH_LOWER_X: begin
                        dec.count = 2'd0;
                        mode_next = MODE_HEX;
                        left_next = HEX_BYTE_DIGITS;
                        byte_next = 1'b1;
                        acc_next  = '0;
                    end
                    CH_LOWER_U: begin
                        dec.count = 2'd0;
                        mode_next = MODE_HEX;
                        left_next = HEX_SHORT_DIGITS;
                        byte_next = 1'b0;
                        acc_next  = '0;
                    end
                    CH_UPPER_U: begin
                        dec.count = 2'd0;
                        mode_next = MODE_HEX;
                        left_next = HEX_LONG_DIGITS;
                        byte_next = 1'b0;
                        acc_next  = '0;
                    end
                    [CH_ZERO:CH_SEVEN]: begin
                        dec.count = 2'd0;
                        mode_next = MODE_OCT;
                        left_next = OCT_MORE_DIGITS;
                        byte_next = 1'b1;
                        acc_next  = {{(ValueW-3){1'b0}}, char_code[2:0]};
                    end
                    CH_LOWER_A:   dec.first = make_result(KIND_CHAR, 32'd7, 1'b0, ERR_NONE);
                    CH_LOWER_B:   dec.first = make_result(KIND_CHAR, 32'd8, 1'b0, ERR_NONE);
                    CH_LOWER_F:   dec.first = make_result(KIND_CHAR, 32'd12, 1'b0, ERR_NONE);
                    CH_LOWER_N:   dec.first = make_result(KIND_CHAR, 32'd10, 1'b0, ERR_NONE);
                    CH_LOWER_R:   dec.first = make_result(KIND_CHAR, 32'd13, 1'b0, ERR_NONE);
                    CH_LOWER_T:   dec.first = make_result(KIND_CHAR, 32'd9, 1'b0, ERR_NONE);
                    CH_LOWER_V:   dec.first = make_result(KIND_CHAR, 32'd11, 1'b0, ERR_NONE);
                    CH_BACKSLASH: dec.first = make_result(KIND_CHAR, 32'd92, 1'b0, ERR_NONE);
                    default: begin
                        dec.first = make_result(KIND_CHAR,
                                                {{(ValueW-CharW){1'b0}}, char_code}, 1'b0,
                                                is_delim ? ERR_NONE : ERR_UNKNOWN);
                    end
                endcase
            end
            MODE_HEX: begin
                if (hex_ok) begin
                    acc_next  = acc_hex;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        mode_next = MODE_NORMAL;
                        dec.count = 2'd1;
                        dec.first = make_result(KIND_CHAR, acc_hex, byte_reg, ERR_NONE);
                    end
                end else begin
                    // Close early, then treat the character as plain text
                    left_next  = '0;
                    mode_next  = plain_esc ? MODE_ESCAPE : MODE_NORMAL;
                    dec.count  = plain_has ? 2'd2 : 2'd1;
                    dec.first  = make_result(KIND_CHAR, acc_reg, byte_reg, ERR_BAD_HEX);
                    dec.second = plain_res;
                end
            end
            MODE_OCT: begin
                if (oct_ok) begin
                    acc_next  = acc_oct;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        mode_next = MODE_NORMAL;
                        dec.count = 2'd1;
                        dec.first = make_result(KIND_CHAR, acc_oct, byte_reg,
                                                (acc_oct > OCT_BYTE_MAX) ? ERR_OCT_RANGE
                                                                         : ERR_NONE);
                    end
                end else begin
                    left_next  = '0;
                    mode_next  = plain_esc ? MODE_ESCAPE : MODE_NORMAL;
                    dec.count  = plain_has ? 2'd2 : 2'd1;
                    dec.first  = make_result(KIND_CHAR, acc_reg, byte_reg, ERR_BAD_OCT);
                    dec.second = plain_res;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
            end
        endcase

        // Mark the final result of this character
        if (dec.count == 2'd1) begin
            dec.first.last = 1'b1;
        end else if (dec.count == 2'd2) begin
            dec.second.last = 1'b1;
        end
    end

    assign dec_out = dec;

    // Advance state on each accepted character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            left_reg <= '0;
            acc_reg  <= '0;
            byte_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            left_reg <= left_next;
            acc_reg  <= acc_next;
            byte_reg <= byte_next;
        end
    end

endmodule

/* design/sed_queue.sv */
// Small result queue that takes up to two results per cycle and gives one.
// Depends on sed_pkg.
module sed_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                push_count,
    input  sed_pkg::result_t          push_first,
    input  sed_pkg::result_t          push_second,
    input  logic                      pop,
    output sed_pkg::result_t          head,
    output logic [sed_pkg::QCntW-1:0] count
);
    import sed_pkg::*;

    result_t            mem [QDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]   count_reg, count_next;
    logic [QPtrW-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = QPtrW'(wr_ptr_reg + push_count);
    assign rd_ptr_next  = rd_ptr_reg + QPtrW'(pop);
    assign count_next   = QCntW'(count_reg + QCntW'(push_count) - QCntW'(pop));

    // Write incoming results
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_plus1] <= push_second;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule
